@@ hw/rtl/gcbi_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gcbi_pkg;

  localparam int COEFS_PER_POINT = 10;
  localparam int COEF_W          = 32;
  localparam int MASS_W          = 24;
  localparam int GS_W            = 6;
  localparam int CIDX_W          = 4;
  localparam int LIDX_W          = 5;
  localparam int CFG_W           = 24;
  localparam int CFG_IDX_W       = 2;
  localparam int FRAC_W          = 34;
  localparam int PT_W            = 8;
  localparam int BASE_W          = 19;

  localparam logic [CIDX_W-1:0] LAST_COEF = CIDX_W'(COEFS_PER_POINT - 1);

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MASS_MIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SPACING = 2'd2;

  localparam logic [GS_W-1:0]   GRID_SIZE_RESET   = 6'd32;
  localparam logic [MASS_W-1:0] MASS_MIN_RESET    = 24'd0;
  localparam logic [MASS_W-1:0] INV_SPACING_RESET = 24'd65536;

  typedef struct packed {
    logic              vld;
    logic [CIDX_W-1:0] k;
    logic              last;
    logic              outside;
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fy;
  } issue_t;

  // Word offset of grid point (a,b) in triangular storage, (max,min) order.
  function automatic logic [BASE_W-1:0] entry_base(input logic [PT_W-1:0] a,
                                                   input logic [PT_W-1:0] b);
    logic [PT_W-1:0]     hi;
    logic [PT_W-1:0]     lo;
    logic [2*PT_W:0]     tri2;
    logic [2*PT_W-1:0]   pt;
    hi   = (a > b) ? a : b;
    lo   = (a > b) ? b : a;
    tri2 = (2*PT_W+1)'(hi) * ((2*PT_W+1)'(hi) + (2*PT_W+1)'(1));
    pt   = tri2[2*PT_W:1] + (2*PT_W)'(lo);
    return BASE_W'(pt) * BASE_W'(COEFS_PER_POINT);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/gcbi_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gcbi_ram #(
  parameter int DEPTH = 5280
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr,
  input  wire logic [gcbi_pkg::COEF_W-1:0]      wdata,
  input  wire logic                             re,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr0,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr1,
  output logic      [gcbi_pkg::COEF_W-1:0]      rdata0,
  output logic      [gcbi_pkg::COEF_W-1:0]      rdata1
);

  logic [gcbi_pkg::COEF_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/gcbi_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gcbi_seq #(
  parameter int MAX_GRID_POINTS = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  input  wire logic [gcbi_pkg::MASS_W-1:0]           mass_a,
  input  wire logic [gcbi_pkg::MASS_W-1:0]           mass_b,
  input  wire logic [gcbi_pkg::GS_W-1:0]             grid_size,
  input  wire logic [gcbi_pkg::MASS_W-1:0]           mass_min,
  input  wire logic [gcbi_pkg::MASS_W-1:0]           inv_spacing,
  input  wire logic                                  en,
  output logic                                       busy,
  output logic                                       rd_en,
  output logic [$clog2(MAX_GRID_POINTS*(MAX_GRID_POINTS+1)/2*gcbi_pkg::COEFS_PER_POINT)-1:0]
                                                     raddr00,
  output logic [$clog2(MAX_GRID_POINTS*(MAX_GRID_POINTS+1)/2*gcbi_pkg::COEFS_PER_POINT)-1:0]
                                                     raddr10,
  output logic [$clog2(MAX_GRID_POINTS*(MAX_GRID_POINTS+1)/2*gcbi_pkg::COEFS_PER_POINT)-1:0]
                                                     raddr01,
  output logic [$clog2(MAX_GRID_POINTS*(MAX_GRID_POINTS+1)/2*gcbi_pkg::COEFS_PER_POINT)-1:0]
                                                     raddr11,
  output gcbi_pkg::issue_t                           issue
);

  localparam int DEPTH    = MAX_GRID_POINTS * (MAX_GRID_POINTS + 1) / 2
                            * gcbi_pkg::COEFS_PER_POINT;
  localparam int AW       = $clog2(DEPTH);
  localparam int IW       = $clog2(MAX_GRID_POINTS);
  localparam int FW       = gcbi_pkg::FRAC_W;
  localparam int N_CAP_I  = (MAX_GRID_POINTS > 63) ? 63 : MAX_GRID_POINTS;
  localparam logic [gcbi_pkg::GS_W-1:0] N_CAP = gcbi_pkg::GS_W'(N_CAP_I);
  localparam logic signed [FW-1:0] ONE_Q16 = 34'sd65536;

  typedef enum logic [1:0] {S_IDLE, S_LOC, S_ADDR, S_RUN} state_t;

  typedef struct packed {
    logic [IW-1:0] idx;
    logic [FW-1:0] frac;
  } loc_t;

  function automatic loc_t locate(input logic [FW-1:0] x,
                                  input logic [gcbi_pkg::GS_W-1:0] n);
    loc_t          r;
    logic [FW-1:0] lim;
    lim = {{(FW-16-gcbi_pkg::GS_W){1'b0}}, n - 6'd1, 16'h0000};
    if (x[FW-1]) begin
      r.idx = '0;
    end else if (x >= lim) begin
      r.idx = IW'(n - 6'd2);
    end else begin
      r.idx = x[16 +: IW];
    end
    r.frac = x - {{(FW-16-IW){1'b0}}, r.idx, 16'h0000};
    return r;
  endfunction

  state_t                       state;
  logic [gcbi_pkg::CIDX_W-1:0]  k;
  logic [FW-1:0]                xa;
  logic [FW-1:0]                xb;
  logic [IW-1:0]                ia;
  logic [IW-1:0]                ib;
  logic [FW-1:0]                fx;
  logic [FW-1:0]                fy;
  logic                         outside;
  logic [AW-1:0]                b00;
  logic [AW-1:0]                b10;
  logic [AW-1:0]                b01;
  logic [AW-1:0]                b11;

  logic signed [gcbi_pkg::MASS_W:0]       diff_a;
  logic signed [gcbi_pkg::MASS_W:0]       diff_b;
  logic signed [2*gcbi_pkg::MASS_W+1:0]   prod_a;
  logic signed [2*gcbi_pkg::MASS_W+1:0]   prod_b;
  logic [gcbi_pkg::GS_W-1:0]              n;
  loc_t                                   la;
  loc_t                                   lb;
  logic [IW-1:0]                          ia1;
  logic [IW-1:0]                          ib1;

  always_comb begin
    diff_a = $signed({1'b0, mass_a}) - $signed({1'b0, mass_min});
    diff_b = $signed({1'b0, mass_b}) - $signed({1'b0, mass_min});
    prod_a = diff_a * $signed({1'b0, inv_spacing});
    prod_b = diff_b * $signed({1'b0, inv_spacing});
    if (grid_size < 6'd2) begin
      n = 6'd2;
    end else if (grid_size > N_CAP) begin
      n = N_CAP;
    end else begin
      n = grid_size;
    end
    la  = locate(xa, n);
    lb  = locate(xb, n);
    ia1 = ia + IW'(1);
    ib1 = ib + IW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            xa    <= prod_a[2*gcbi_pkg::MASS_W+1:16];
            xb    <= prod_b[2*gcbi_pkg::MASS_W+1:16];
            state <= S_LOC;
          end
        end
        S_LOC: begin
          ia      <= la.idx;
          ib      <= lb.idx;
          fx      <= la.frac;
          fy      <= lb.frac;
          outside <= la.frac[FW-1] || ($signed(la.frac) > ONE_Q16) ||
                     lb.frac[FW-1] || ($signed(lb.frac) > ONE_Q16);
          state   <= S_ADDR;
        end
        S_ADDR: begin
          b00   <= AW'(gcbi_pkg::entry_base(gcbi_pkg::PT_W'(ia),  gcbi_pkg::PT_W'(ib)));
          b10   <= AW'(gcbi_pkg::entry_base(gcbi_pkg::PT_W'(ia1), gcbi_pkg::PT_W'(ib)));
          b01   <= AW'(gcbi_pkg::entry_base(gcbi_pkg::PT_W'(ia),  gcbi_pkg::PT_W'(ib1)));
          b11   <= AW'(gcbi_pkg::entry_base(gcbi_pkg::PT_W'(ia1), gcbi_pkg::PT_W'(ib1)));
          k     <= '0;
          state <= S_RUN;
        end
        S_RUN: begin
          if (en) begin
            if (k == gcbi_pkg::LAST_COEF) begin
              k     <= '0;
              state <= S_IDLE;
            end else begin
              k <= k + 4'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    busy          = (state != S_IDLE);
    issue.vld     = (state == S_RUN);
    issue.k       = k;
    issue.last    = (k == gcbi_pkg::LAST_COEF);
    issue.outside = outside;
    issue.fx      = fx;
    issue.fy      = fy;
    rd_en         = issue.vld && en;
    raddr00       = b00 + AW'(k);
    raddr10       = b10 + AW'(k);
    raddr01       = b01 + AW'(k);
    raddr11       = b11 + AW'(k);
  end

endmodule

`default_nettype wire

@@ hw/rtl/gcbi_interp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gcbi_interp (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 en,
  input  wire gcbi_pkg::issue_t                     issue,
  input  wire logic [gcbi_pkg::COEF_W-1:0]          rd00,
  input  wire logic [gcbi_pkg::COEF_W-1:0]          rd10,
  input  wire logic [gcbi_pkg::COEF_W-1:0]          rd01,
  input  wire logic [gcbi_pkg::COEF_W-1:0]          rd11,
  output logic                                      out_valid,
  output logic [gcbi_pkg::CIDX_W-1:0]               coef_index,
  output logic signed [gcbi_pkg::COEF_W-1:0]        coef_value,
  output logic                                      outside_grid,
  output logic                                      last
);

  localparam int FW = gcbi_pkg::FRAC_W;
  localparam int HW = FW - 16;
  localparam logic signed [51:0] SAT_HI = 52'sd2147483647;
  localparam logic signed [51:0] SAT_LO = -52'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7FFFFFFF;
    end else if (v < SAT_LO) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  gcbi_pkg::issue_t m1;
  gcbi_pkg::issue_t m2;
  gcbi_pkg::issue_t m3;
  gcbi_pkg::issue_t m4;
  logic v1;
  logic v2;
  logic v3;
  logic v4;

  logic signed [31:0] a0;
  logic signed [31:0] a1;
  logic signed [50:0] h0;
  logic signed [50:0] h1;
  logic signed [49:0] l0;
  logic signed [49:0] l1;
  logic signed [31:0] t1;
  logic signed [31:0] t2;
  logic signed [31:0] c0;
  logic signed [50:0] gh;
  logic signed [49:0] gl;

  logic signed [31:0] p00;
  logic signed [31:0] p10;
  logic signed [31:0] p01;
  logic signed [31:0] p11;
  logic signed [32:0] d0;
  logic signed [32:0] d1;
  logic signed [32:0] dy;
  logic signed [HW-1:0] fxh;
  logic signed [16:0]   fxl;
  logic signed [HW-1:0] fyh;
  logic signed [16:0]   fyl;
  logic signed [51:0] s0;
  logic signed [51:0] s1;
  logic signed [51:0] sv;

  always_comb begin
    p00 = $signed(rd00);
    p10 = $signed(rd10);
    p01 = $signed(rd01);
    p11 = $signed(rd11);
    d0  = p10 - p00;
    d1  = p11 - p01;
    fxh = $signed(m1.fx[FW-1:16]);
    fxl = $signed({1'b0, m1.fx[15:0]});
    s0  = a0 + h0 + (l0 >>> 16);
    s1  = a1 + h1 + (l1 >>> 16);
    dy  = t2 - t1;
    fyh = $signed(m3.fy[FW-1:16]);
    fyl = $signed({1'b0, m3.fy[15:0]});
    sv  = c0 + gh + (gl >>> 16);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= issue.vld;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1           <= issue;
      m2           <= m1;
      a0           <= p00;
      a1           <= p01;
      h0           <= fxh * d0;
      l0           <= fxl * d0;
      h1           <= fxh * d1;
      l1           <= fxl * d1;
      m3           <= m2;
      t1           <= sat32(s0);
      t2           <= sat32(s1);
      m4           <= m3;
      c0           <= t1;
      gh           <= fyh * dy;
      gl           <= fyl * dy;
      coef_index   <= m4.k;
      coef_value   <= sat32(sv);
      outside_grid <= m4.outside;
      last         <= m4.last;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/grid_coefficient_bilinear_interp.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  handshake               payload
// in       in   in_valid / in_stall     req_type, load_row, load_col, load_coef_index,
//                                       load_value, query_mass_a, query_mass_b
// out      out  out_valid / out_stall   coef_index, coef_value, outside_grid, last
// cfg      in   cfg_write               cfg_index, cfg_data
//
// A load never raises in_stall. A query holds in_stall after its transfer while it does
// locate, corner addressing and ten read issues, so the next request waits for those.
// Four corner reads per cycle come from two copies of the store, each read at two ports.
// Results pass read, x-product, edge, y-product and output stages, then follow each cycle.
// Reset clears control only; store contents are undefined until loaded.
// out_stall with out_valid high freezes read issue and the whole interpolation pipeline.

module grid_coefficient_bilinear_interp #(
  parameter int MAX_GRID_POINTS = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 req_type,
  input  wire logic [gcbi_pkg::LIDX_W-1:0]          load_row,
  input  wire logic [gcbi_pkg::LIDX_W-1:0]          load_col,
  input  wire logic [gcbi_pkg::CIDX_W-1:0]          load_coef_index,
  input  wire logic signed [gcbi_pkg::COEF_W-1:0]   load_value,
  input  wire logic [gcbi_pkg::MASS_W-1:0]          query_mass_a,
  input  wire logic [gcbi_pkg::MASS_W-1:0]          query_mass_b,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [gcbi_pkg::CIDX_W-1:0]               coef_index,
  output logic signed [gcbi_pkg::COEF_W-1:0]        coef_value,
  output logic                                      outside_grid,
  output logic                                      last,
  input  wire logic                                 cfg_write,
  input  wire logic [gcbi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [gcbi_pkg::CFG_W-1:0]           cfg_data
);

  localparam int DEPTH = MAX_GRID_POINTS * (MAX_GRID_POINTS + 1) / 2
                         * gcbi_pkg::COEFS_PER_POINT;
  localparam int AW    = $clog2(DEPTH);

  logic [gcbi_pkg::GS_W-1:0]   grid_size;
  logic [gcbi_pkg::MASS_W-1:0] mass_min;
  logic [gcbi_pkg::MASS_W-1:0] inv_spacing;

  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic [gcbi_pkg::COEF_W-1:0]   wr_data;

  logic                          in_xfer;
  logic                          load_ok;
  logic                          start;
  logic                          busy;
  logic                          en;
  logic                          rd_en;
  logic [AW-1:0]                 raddr00;
  logic [AW-1:0]                 raddr10;
  logic [AW-1:0]                 raddr01;
  logic [AW-1:0]                 raddr11;
  logic [gcbi_pkg::COEF_W-1:0]   rd00;
  logic [gcbi_pkg::COEF_W-1:0]   rd10;
  logic [gcbi_pkg::COEF_W-1:0]   rd01;
  logic [gcbi_pkg::COEF_W-1:0]   rd11;
  gcbi_pkg::issue_t              issue;

  assign in_stall = busy;
  assign in_xfer  = in_valid && !in_stall;
  assign start    = in_xfer && (req_type == gcbi_pkg::REQ_QUERY);
  assign load_ok  = (load_coef_index < gcbi_pkg::CIDX_W'(gcbi_pkg::COEFS_PER_POINT)) &&
                    (int'(load_row) < MAX_GRID_POINTS) &&
                    (int'(load_col) < MAX_GRID_POINTS);
  assign en       = !(out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size   <= gcbi_pkg::GRID_SIZE_RESET;
      mass_min    <= gcbi_pkg::MASS_MIN_RESET;
      inv_spacing <= gcbi_pkg::INV_SPACING_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        gcbi_pkg::REG_GRID_SIZE:   grid_size   <= cfg_data[gcbi_pkg::GS_W-1:0];
        gcbi_pkg::REG_MASS_MIN:    mass_min    <= cfg_data;
        gcbi_pkg::REG_INV_SPACING: inv_spacing <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_en <= 1'b0;
    end else begin
      wr_en <= in_xfer && (req_type == gcbi_pkg::REQ_LOAD) && load_ok;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr <= AW'(gcbi_pkg::entry_base(gcbi_pkg::PT_W'(load_row),
                                        gcbi_pkg::PT_W'(load_col)))
               + AW'(load_coef_index);
    wr_data <= load_value;
  end

  gcbi_ram #(.DEPTH(DEPTH)) u_ram_lo (
    .clk    (clk),
    .we     (wr_en),
    .waddr  (wr_addr),
    .wdata  (wr_data),
    .re     (rd_en),
    .raddr0 (raddr00),
    .raddr1 (raddr10),
    .rdata0 (rd00),
    .rdata1 (rd10)
  );

  gcbi_ram #(.DEPTH(DEPTH)) u_ram_hi (
    .clk    (clk),
    .we     (wr_en),
    .waddr  (wr_addr),
    .wdata  (wr_data),
    .re     (rd_en),
    .raddr0 (raddr01),
    .raddr1 (raddr11),
    .rdata0 (rd01),
    .rdata1 (rd11)
  );

  gcbi_seq #(.MAX_GRID_POINTS(MAX_GRID_POINTS)) u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .mass_a      (query_mass_a),
    .mass_b      (query_mass_b),
    .grid_size   (grid_size),
    .mass_min    (mass_min),
    .inv_spacing (inv_spacing),
    .en          (en),
    .busy        (busy),
    .rd_en       (rd_en),
    .raddr00     (raddr00),
    .raddr10     (raddr10),
    .raddr01     (raddr01),
    .raddr11     (raddr11),
    .issue       (issue)
  );

  gcbi_interp u_interp (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .issue        (issue),
    .rd00         (rd00),
    .rd10         (rd10),
    .rd01         (rd01),
    .rd11         (rd11),
    .out_valid    (out_valid),
    .coef_index   (coef_index),
    .coef_value   (coef_value),
    .outside_grid (outside_grid),
    .last         (last)
  );

endmodule

`default_nettype wire

@@ hw/rtl/gcbi_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gcbi_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                in_valid,
  input wire logic                                in_stall,
  input wire logic                                req_type,
  input wire logic                                out_valid,
  input wire logic                                out_stall,
  input wire logic [gcbi_pkg::CIDX_W-1:0]         coef_index,
  input wire logic signed [gcbi_pkg::COEF_W-1:0]  coef_value,
  input wire logic                                outside_grid,
  input wire logic                                last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(coef_value) &&
      $stable(coef_index) && $stable(last) && $stable(outside_grid))
    else $error("stalled result changed");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (coef_index == gcbi_pkg::LAST_COEF)))
    else $error("last flag does not match final coefficient");

  a_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid &&
      (coef_index == $past(coef_index) + 4'd1) && $stable(outside_grid))
    else $error("query results not consecutive");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (req_type == gcbi_pkg::REQ_QUERY) |=> in_stall)
    else $error("input open right after query transfer");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("control not cleared by reset");

endmodule

bind grid_coefficient_bilinear_interp gcbi_checker u_checker (.*);

`default_nettype wire

@@ dv/interp_checker.sv @@
`timescale 1ns / 1ps

module interp_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic                                  req_type,
  input  logic [gcbi_pkg::LIDX_W-1:0]           load_row,
  input  logic [gcbi_pkg::LIDX_W-1:0]           load_col,
  input  logic [gcbi_pkg::CIDX_W-1:0]           load_coef_index,
  input  logic signed [gcbi_pkg::COEF_W-1:0]    load_value,
  input  logic [gcbi_pkg::MASS_W-1:0]           query_mass_a,
  input  logic [gcbi_pkg::MASS_W-1:0]           query_mass_b,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic [gcbi_pkg::CIDX_W-1:0]           coef_index,
  input  logic signed [gcbi_pkg::COEF_W-1:0]    coef_value,
  input  logic                                  outside_grid,
  input  logic                                  last,
  input  logic                                  cfg_write,
  input  logic [gcbi_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [gcbi_pkg::CFG_W-1:0]            cfg_data,
  output int                                    errors,
  output int                                    pending,
  output int                                    checked
);

  localparam int     GRID_MAX    = 32;
  localparam int     STORE_WORDS = GRID_MAX * (GRID_MAX + 1) / 2 * gcbi_pkg::COEFS_PER_POINT;
  localparam longint Q16_ONE     = 65536;

  typedef struct packed {
    logic [gcbi_pkg::CIDX_W-1:0] k;
    logic [gcbi_pkg::COEF_W-1:0] value;
    logic                        outside;
    logic                        last;
  } coef_result_t;

  logic [gcbi_pkg::COEF_W-1:0] coef_mem [STORE_WORDS];
  logic [gcbi_pkg::GS_W-1:0]   grid_size_q;
  logic [gcbi_pkg::MASS_W-1:0] mass_min_q;
  logic [gcbi_pkg::MASS_W-1:0] inv_spacing_q;
  coef_result_t                coef_results_due [$];
  coef_result_t                head;

  function automatic int word_addr(int a, int b, int k);
    int hi;
    int lo;
    hi = (a > b) ? a : b;
    lo = a + b - hi;
    return (hi * (hi + 1) / 2 + lo) * gcbi_pkg::COEFS_PER_POINT + k;
  endfunction

  function automatic longint coef_at(int a, int b, int k);
    logic signed [gcbi_pkg::COEF_W-1:0] w;
    w = coef_mem[word_addr(a, b, k)];
    return longint'(w);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  // floor(((1-f)*p + f*q) / 2^16), split so the products stay in 64 bits
  function automatic longint blend(longint f, longint p, longint q);
    longint d;
    longint fh;
    longint fl;
    d  = q - p;
    fh = f >>> 16;
    fl = f - fh * Q16_ONE;
    return clamp32(p + fh * d + ((fl * d) >>> 16));
  endfunction

  function automatic void find_cell(input logic [gcbi_pkg::MASS_W-1:0] mass, input int n,
                                    output int idx, output longint frac);
    longint x;
    x = ((longint'(mass) - longint'(mass_min_q)) * longint'(inv_spacing_q)) >>> 16;
    if (x < 0) idx = 0;
    else if (x >= longint'(n - 1) * Q16_ONE) idx = n - 2;
    else idx = int'(x >>> 16);
    frac = x - longint'(idx) * Q16_ONE;
  endfunction

  task automatic interp_coefs(input logic [gcbi_pkg::MASS_W-1:0] ma,
                              input logic [gcbi_pkg::MASS_W-1:0] mb);
    int           n;
    int           i;
    int           j;
    longint       fx;
    longint       fy;
    longint       lo_edge;
    longint       hi_edge;
    longint       v;
    logic         outside;
    coef_result_t r;
    n = int'(grid_size_q);
    if (n < 2) n = 2;
    if (n > GRID_MAX) n = GRID_MAX;
    find_cell(ma, n, i, fx);
    find_cell(mb, n, j, fy);
    outside = (fx < 0) || (fx > Q16_ONE) || (fy < 0) || (fy > Q16_ONE);
    for (int k = 0; k < gcbi_pkg::COEFS_PER_POINT; k++) begin
      lo_edge   = blend(fx, coef_at(i, j, k), coef_at(i + 1, j, k));
      hi_edge   = blend(fx, coef_at(i, j + 1, k), coef_at(i + 1, j + 1, k));
      v         = blend(fy, lo_edge, hi_edge);
      r.k       = gcbi_pkg::CIDX_W'(k);
      r.value   = v[gcbi_pkg::COEF_W-1:0];
      r.outside = outside;
      r.last    = (k == gcbi_pkg::COEFS_PER_POINT - 1);
      coef_results_due.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string msg);
    errors++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      grid_size_q   = gcbi_pkg::GRID_SIZE_RESET;
      mass_min_q    = gcbi_pkg::MASS_MIN_RESET;
      inv_spacing_q = gcbi_pkg::INV_SPACING_RESET;
      coef_results_due.delete();
      errors        = 0;
      checked       = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (coef_results_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result, coef %0d value %0d",
                                    coef_index, coef_value));
        end else begin
          head = coef_results_due.pop_front();
          checked++;
          if (coef_index !== head.k)
            report_mismatch($sformatf("coef_index %0d, want %0d", coef_index, head.k));
          if (coef_value !== head.value)
            report_mismatch($sformatf("coef %0d value %0d, want %0d", head.k,
                                      coef_value, $signed(head.value)));
          if (outside_grid !== head.outside)
            report_mismatch($sformatf("coef %0d outside_grid %b, want %b", head.k,
                                      outside_grid, head.outside));
          if (last !== head.last)
            report_mismatch($sformatf("coef %0d last %b, want %b", head.k, last,
                                      head.last));
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          gcbi_pkg::REG_GRID_SIZE:   grid_size_q   = cfg_data[gcbi_pkg::GS_W-1:0];
          gcbi_pkg::REG_MASS_MIN:    mass_min_q    = cfg_data[gcbi_pkg::MASS_W-1:0];
          gcbi_pkg::REG_INV_SPACING: inv_spacing_q = cfg_data[gcbi_pkg::MASS_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (req_type == gcbi_pkg::REQ_QUERY)
          interp_coefs(query_mass_a, query_mass_b);
        else if (int'(load_coef_index) < gcbi_pkg::COEFS_PER_POINT)
          coef_mem[word_addr(int'(load_row), int'(load_col), int'(load_coef_index))] =
            load_value;
      end
    end
    pending <= coef_results_due.size();
  end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int GRID_MAX = 32;

  logic                               clk             = 1'b0;
  logic                               rst             = 1'b1;
  logic                               in_valid        = 1'b0;
  logic                               req_type        = gcbi_pkg::REQ_LOAD;
  logic [gcbi_pkg::LIDX_W-1:0]        load_row        = '0;
  logic [gcbi_pkg::LIDX_W-1:0]        load_col        = '0;
  logic [gcbi_pkg::CIDX_W-1:0]        load_coef_index = '0;
  logic signed [gcbi_pkg::COEF_W-1:0] load_value      = '0;
  logic [gcbi_pkg::MASS_W-1:0]        query_mass_a    = '0;
  logic [gcbi_pkg::MASS_W-1:0]        query_mass_b    = '0;
  logic                               out_stall       = 1'b0;
  logic                               cfg_write       = 1'b0;
  logic [gcbi_pkg::CFG_IDX_W-1:0]     cfg_index       = '0;
  logic [gcbi_pkg::CFG_W-1:0]         cfg_data        = '0;

  logic                               in_stall;
  logic                               out_valid;
  logic [gcbi_pkg::CIDX_W-1:0]        coef_index;
  logic signed [gcbi_pkg::COEF_W-1:0] coef_value;
  logic                               outside_grid;
  logic                               last_result;

  int errors;
  int pending;
  int checked;

  int                          gs_mirror   = int'(gcbi_pkg::GRID_SIZE_RESET);
  logic [gcbi_pkg::MASS_W-1:0] min_mirror  = gcbi_pkg::MASS_MIN_RESET;
  logic [gcbi_pkg::MASS_W-1:0] inv_mirror  = gcbi_pkg::INV_SPACING_RESET;
  bit   have_coef [0:GRID_MAX-1][0:GRID_MAX-1][0:gcbi_pkg::COEFS_PER_POINT-1];
  int                          n_loads     = 0;
  int                          n_ignored   = 0;
  int                          n_queries   = 0;
  int                          sender_idle = 0;
  int                          receiver_stall = 0;
  int                          hold_seq    = 0;
  int                          hold_seen   = 0;
  int                          hold_left   = 0;

  always #5 clk = ~clk;

  grid_coefficient_bilinear_interp uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .req_type        (req_type),
    .load_row        (load_row),
    .load_col        (load_col),
    .load_coef_index (load_coef_index),
    .load_value      (load_value),
    .query_mass_a    (query_mass_a),
    .query_mass_b    (query_mass_b),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .coef_index      (coef_index),
    .coef_value      (coef_value),
    .outside_grid    (outside_grid),
    .last            (last_result),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  interp_checker interp_chk (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .req_type        (req_type),
    .load_row        (load_row),
    .load_col        (load_col),
    .load_coef_index (load_coef_index),
    .load_value      (load_value),
    .query_mass_a    (query_mass_a),
    .query_mass_b    (query_mass_b),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .coef_index      (coef_index),
    .coef_value      (coef_value),
    .outside_grid    (outside_grid),
    .last            (last_result),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .errors          (errors),
    .pending         (pending),
    .checked         (checked)
  );

  // hold off for a long stretch each time hold_seq is bumped, else stall at random
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < receiver_stall);
      end
    end
  end

  task automatic transfer(input logic rq, input logic [gcbi_pkg::LIDX_W-1:0] r,
                          input logic [gcbi_pkg::LIDX_W-1:0] c,
                          input logic [gcbi_pkg::CIDX_W-1:0] ci,
                          input logic [gcbi_pkg::COEF_W-1:0] v,
                          input logic [gcbi_pkg::MASS_W-1:0] ma,
                          input logic [gcbi_pkg::MASS_W-1:0] mb);
    while ($urandom_range(99) < sender_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    req_type        <= rq;
    load_row        <= r;
    load_col        <= c;
    load_coef_index <= ci;
    load_value      <= v;
    query_mass_a    <= ma;
    query_mass_b    <= mb;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [gcbi_pkg::MASS_W-1:0] any_mass();
    return gcbi_pkg::MASS_W'($urandom_range(24'hFFFFFF));
  endfunction

  task automatic load_coef(input int r, input int c, input int k,
                           input logic [gcbi_pkg::COEF_W-1:0] v);
    transfer(gcbi_pkg::REQ_LOAD, gcbi_pkg::LIDX_W'(r), gcbi_pkg::LIDX_W'(c),
             gcbi_pkg::CIDX_W'(k), v, any_mass(), any_mass());
    if (k < gcbi_pkg::COEFS_PER_POINT) begin
      have_coef[r][c][k] = 1'b1;
      have_coef[c][r][k] = 1'b1;
      n_loads++;
    end else begin
      n_ignored++;
    end
  endtask

  function automatic logic [gcbi_pkg::COEF_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [gcbi_pkg::MASS_W-1:0] pick_mass(input int lo, input int span);
    int m;
    if ($urandom_range(3) == 0) return any_mass();
    m = lo + int'($urandom_range(span));
    return (m > 32'h00FF_FFFF) ? 24'hFFFFFF : m[gcbi_pkg::MASS_W-1:0];
  endfunction

  // lower cell corner a query will read under the current registers
  function automatic int corner_of(input logic [gcbi_pkg::MASS_W-1:0] mass);
    int     n;
    longint x;
    n = gs_mirror;
    if (n < 2) n = 2;
    if (n > GRID_MAX) n = GRID_MAX;
    x = ((longint'(mass) - longint'(min_mirror)) * longint'(inv_mirror)) >>> 16;
    if (x < 0) return 0;
    if (x >= longint'(n - 1) * 65536) return n - 2;
    return int'(x >>> 16);
  endfunction

  task automatic query(input logic [gcbi_pkg::MASS_W-1:0] ma,
                       input logic [gcbi_pkg::MASS_W-1:0] mb);
    int i;
    int j;
    i = corner_of(ma);
    j = corner_of(mb);
    for (int a = i; a <= i + 1; a++)
      for (int b = j; b <= j + 1; b++)
        for (int k = 0; k < gcbi_pkg::COEFS_PER_POINT; k++)
          if (!have_coef[a][b][k]) begin
            if ($urandom_range(1)) load_coef(a, b, k, pick_value());
            else load_coef(b, a, k, pick_value());
          end
    transfer(gcbi_pkg::REQ_QUERY, gcbi_pkg::LIDX_W'($urandom_range(31)),
             gcbi_pkg::LIDX_W'($urandom_range(31)), gcbi_pkg::CIDX_W'($urandom_range(15)),
             $urandom, ma, mb);
    n_queries++;
  endtask

  task automatic write_reg(input logic [gcbi_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gcbi_pkg::CFG_W-1:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    case (idx)
      gcbi_pkg::REG_GRID_SIZE:   gs_mirror  = int'(d[gcbi_pkg::GS_W-1:0]);
      gcbi_pkg::REG_MASS_MIN:    min_mirror = d[gcbi_pkg::MASS_W-1:0];
      gcbi_pkg::REG_INV_SPACING: inv_mirror = d[gcbi_pkg::MASS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input int gs, input logic [gcbi_pkg::MASS_W-1:0] mmin,
                          input logic [gcbi_pkg::MASS_W-1:0] inv);
    write_reg(gcbi_pkg::REG_GRID_SIZE, {18'($urandom), 6'(gs)});
    write_reg(gcbi_pkg::REG_MASS_MIN, mmin);
    write_reg(gcbi_pkg::REG_INV_SPACING, inv);
    cfg_write <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_phase(input int items, input int lo, input int span,
                              input int sidle, input int rstall);
    int goal;
    sender_idle    = sidle;
    receiver_stall <= rstall;
    goal = n_loads + n_queries + items;
    while (n_loads + n_queries < goal) begin
      case ($urandom_range(9))
        0, 1:    load_coef($urandom_range(31), $urandom_range(31),
                           $urandom_range(gcbi_pkg::COEFS_PER_POINT - 1), pick_value());
        2:       load_coef($urandom_range(31), $urandom_range(31),
                           $urandom_range(15, gcbi_pkg::COEFS_PER_POINT), $urandom);
        default: query(pick_mass(lo, span), pick_mass(lo, span));
      endcase
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // two-point grid from 1.0 to 2.0: corners, edges, just outside, far outside
    set_regs(2, 24'h010000, 24'h010000);
    for (int k = 0; k < 3; k++) begin
      load_coef(0, 0, k, 32'h7FFF_FFFF);
      load_coef(1, 1, k, 32'h8000_0000);
    end
    load_coef(31, 0, int'(gcbi_pkg::LAST_COEF), 32'h8000_0000);
    load_coef(31, 31, 4, 32'hFFFF_FFFF);
    load_coef(17, 5, 15, 32'h1234_5678);
    load_coef(2, 30, 10, 32'hFFFF_FFFF);
    query(24'h010000, 24'h010000);
    query(24'h020000, 24'h020000);
    query(24'h018000, 24'h01C000);
    query(24'h020001, 24'h00FFFF);
    query(24'h000000, 24'hFFFFFF);
    query(24'hFFFFFF, 24'hFFFFFF);
    query(24'h015555, 24'h000000);
    drain();

    set_regs(32, 24'h000000, 24'h010000);
    random_phase(20, 24'h1C0000, 24'h050000, 0, 0);
    drain();

    set_regs(8, 24'h123456, 24'h00C000);
    random_phase(20, 24'h100000, 24'h0C0000, 83, 0);
    drain();

    // zero reciprocal: every mass maps to the first cell
    set_regs(1, 24'h7FFFFF, 24'h000000);
    random_phase(10, 0, 24'hFFFFFF, 0, 83);
    drain();
    random_phase(10, 0, 24'hFFFFFF, 0, 83);
    drain();

    set_regs(63, 24'hFFFFFF, 24'hFFFFFF);
    random_phase(10, 24'hFFFF00, 24'h0000FF, 30, 30);
    drain();

    // fill the block while the output is held off
    set_regs(0, 24'h000000, 24'h000001);
    hold_seq <= hold_seq + 1;
    random_phase(10, 0, 24'hFFFFFF, 0, 0);
    drain();

    $display("Covered %0d coefficient loads (%0d ignored) and %0d queries, %0d results checked,",
             n_loads, n_ignored, n_queries, checked);
    $display("over six register settings including grid size, offset and spacing extremes.");
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/gcbi_pkg.sv
hw/rtl/gcbi_ram.sv
hw/rtl/gcbi_seq.sv
hw/rtl/gcbi_interp.sv
hw/rtl/grid_coefficient_bilinear_interp.sv
hw/rtl/gcbi_checker.sv
dv/interp_checker.sv
dv/tb.sv
